// ===== rtl/pftk_pkg.sv =====
// ----------------------------------------------------------------------------
// pftk_pkg
// shared types and constants of the prime filter and top-k tracker
// ----------------------------------------------------------------------------
package pftk_pkg;

    localparam int CAND_W  = 31;               // candidate and list value width
    localparam int COUNT_W = 31;
    localparam int TOTAL_W = 63;
    localparam int DIV_W   = 17;               // trial divisor width, d*d < 2^31
    localparam int REM_W   = DIV_W + 1;
    localparam int SQ_W    = 2 * DIV_W;
    localparam int ODATA_W = 128;

    localparam logic [DIV_W-1:0] C_DIV_THREE = 17'd3;
    localparam logic [DIV_W-1:0] C_DIV_FIRST = 17'd5;
    localparam logic [DIV_W-1:0] C_DIV_PAIR  = 17'd2;
    localparam logic [DIV_W-1:0] C_DIV_STEP  = 17'd6;

    localparam logic [COUNT_W-1:0] C_COUNT_MAX = '1;
    localparam logic [TOTAL_W-1:0] C_TOTAL_MAX = '1;

    localparam logic C_KIND_TEST = 1'b0;
    localparam logic C_KIND_LIST = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PRE,
        ST_WAIT3,
        ST_MUL,
        ST_CMP,
        ST_WAITA,
        ST_WAITB,
        ST_UPD,
        ST_RES,
        ST_LIST
    } t_state;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] divisor;
    } t_rem_req;

    typedef struct packed {
        logic done;
        logic zero;
    } t_rem_rsp;

endpackage

// ===== rtl/pftk_rem.sv =====
// ----------------------------------------------------------------------------
// pftk_rem
// restoring remainder unit, one dividend bit per cycle
// ----------------------------------------------------------------------------
module pftk_rem
    import pftk_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [CAND_W-1:0] i_dividend,
    input  t_rem_req          i_req,
    output t_rem_rsp          o_rsp
);

    localparam int CNT_W = $clog2(CAND_W + 1);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [CAND_W-1:0] r_dvd, n_dvd;
    logic [DIV_W-1:0]  r_dvs, n_dvs;
    logic [REM_W-1:0]  r_rem, n_rem;
    logic [REM_W-1:0]  w_trial;

    assign w_trial = {r_rem[REM_W-2:0], r_dvd[CAND_W-1]};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_dvd  = r_dvd;
        n_dvs  = r_dvs;
        n_rem  = r_rem;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(CAND_W);
            n_dvd  = i_dividend;
            n_dvs  = i_req.divisor;
            n_rem  = '0;
        end else if (r_busy) begin
            // shift in one bit, subtract when it fits
            if (w_trial >= {1'b0, r_dvs}) begin
                n_rem = w_trial - {1'b0, r_dvs};
            end else begin
                n_rem = w_trial;
            end
            n_dvd = {r_dvd[CAND_W-2:0], 1'b0};
            n_cnt = r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_dvd <= n_dvd;
        r_dvs <= n_dvs;
        r_rem <= n_rem;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.zero = (r_rem == '0);

endmodule

// ===== rtl/pftk_list.sv =====
// ----------------------------------------------------------------------------
// pftk_list
// descending list of the largest primes, with a registered sorted insert
// ----------------------------------------------------------------------------
module pftk_list
    import pftk_pkg::*;
#(
    parameter int LIST_DEPTH = 10
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         i_ins,
    input  logic [CAND_W-1:0]                            i_val,
    input  logic [((LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1)-1:0] i_rd_idx,
    output logic [CAND_W-1:0]                            o_rd_val,
    output logic [$clog2(LIST_DEPTH + 1)-1:0]            o_fill
);

    localparam int FILL_W = $clog2(LIST_DEPTH + 1);

    logic [CAND_W-1:0] r_list [LIST_DEPTH];
    logic [CAND_W-1:0] n_list [LIST_DEPTH];
    logic [FILL_W-1:0] r_fill;
    logic [LIST_DEPTH-1:0] w_ge;
    logic              w_full;

    assign w_full = (r_fill == FILL_W'(LIST_DEPTH));

    // each entry looks at itself and its upper neighbour only
    for (genvar j = 0; j < LIST_DEPTH; j++) begin : g_ent
        assign w_ge[j] = (FILL_W'(j) < r_fill) && (r_list[j] >= i_val);
        if (j == 0) begin : g_top
            assign n_list[j] = w_ge[j] ? r_list[j] : i_val;
        end else begin : g_rest
            assign n_list[j] = w_ge[j]     ? r_list[j]   :
                               w_ge[j - 1] ? i_val       : r_list[j - 1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_ins && !w_full) begin
            r_fill <= r_fill + FILL_W'(1);
        end
        if (i_ins) begin
            r_list <= n_list;
        end
    end

    assign o_rd_val = r_list[i_rd_idx];
    assign o_fill   = r_fill;

endmodule

// ===== rtl/prime_filter_top_k_tracker.sv =====
// ----------------------------------------------------------------------------
// prime_filter_top_k_tracker
// trial-division prime test with running count, sum and largest-k list
// ----------------------------------------------------------------------------
// usage
//   s_axis: one candidate request per item, tdata[30:0] candidate, tlast asks
//   for the stored list after the test result
//   m_axis: tuser 0 = test result, 1 = list entry (smallest first); tlast
//   marks the last result of a request
// sequence
//   s_axis_tready is high only while idle; one request is worked at a time
//   values below 4 and even values skip the trial loop and go straight to the
//   update and result states; others first test by 3, then per divisor pair
//   square, compare and up to two remainders on the one shared remainder unit,
//   for roughly sqrt(n)/6 pairs; then the test result and, for a final item,
//   the list entries, each held in the output register while m_axis_tready is low
// reset
//   synchronous active low; clears count, sum and list fill, drops tvalid
// stall
//   results sit in one output register; the sequencer waits while it is full
//   and m_axis_tready is low, nothing is lost
// ----------------------------------------------------------------------------
module prime_filter_top_k_tracker
    import pftk_pkg::*;
#(
    parameter int LIST_DEPTH = 10,
    parameter int VALUE_BITS = 31
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [31:0]        s_axis_tdata,   // [30:0] candidate, [31] zero
    input  logic               s_axis_tlast,   // final_item
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [ODATA_W-1:0] m_axis_tdata,   // [0] prime_flag, [31:1] prime_count,
                                               // [94:32] prime_total,
                                               // [125:95] list_value, [127:126] zero
    output logic               m_axis_tuser,   // kind
    output logic               m_axis_tlast    // end_of_run
);

    localparam int FILL_W = $clog2(LIST_DEPTH + 1);
    localparam int IDX_W  = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam logic [CAND_W-1:0] VMASK =
        (VALUE_BITS >= CAND_W) ? {CAND_W{1'b1}} : CAND_W'((64'd1 << VALUE_BITS) - 64'd1);

    t_state r_state, n_state;

    logic [CAND_W-1:0]  r_n, n_n;
    logic               r_fin, n_fin;
    logic               r_isp, n_isp;
    logic [DIV_W-1:0]   r_d, n_d;
    logic [SQ_W-1:0]    r_sq, n_sq;
    logic [COUNT_W-1:0] r_count, n_count;
    logic [TOTAL_W-1:0] r_total, n_total;
    logic [IDX_W-1:0]   r_idx, n_idx;

    logic               r_ovalid, n_ovalid;
    logic [ODATA_W-1:0] r_odata, n_odata;
    logic               r_ouser, n_ouser;
    logic               r_olast, n_olast;

    t_rem_req           w_req;
    t_rem_rsp           w_rsp;
    logic               w_ins;
    logic [CAND_W-1:0]  w_rd_val;
    logic [FILL_W-1:0]  w_fill;
    logic               w_out_free;
    logic               w_small;
    logic               w_trivial_no;
    logic [TOTAL_W:0]   w_sum;

    assign w_out_free   = !r_ovalid || m_axis_tready;
    assign w_small      = (r_n == CAND_W'(2)) || (r_n == CAND_W'(3));
    assign w_trivial_no = (r_n < CAND_W'(2)) || !r_n[0];
    assign w_sum        = {1'b0, r_total} + {{(TOTAL_W - CAND_W + 1){1'b0}}, r_n};

    // shared remainder unit, used for n mod 3 and every trial divisor
    pftk_rem u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_dividend (r_n),
        .i_req      (w_req),
        .o_rsp      (w_rsp)
    );

    pftk_list #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_list (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ins    (w_ins),
        .i_val    (r_n),
        .i_rd_idx (r_idx),
        .o_rd_val (w_rd_val),
        .o_fill   (w_fill)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = ST_PRE;
                end
            end
            ST_PRE: begin
                n_state = (w_small || w_trivial_no) ? ST_UPD : ST_WAIT3;
            end
            ST_WAIT3: begin
                if (w_rsp.done) begin
                    n_state = w_rsp.zero ? ST_UPD : ST_MUL;
                end
            end
            ST_MUL: n_state = ST_CMP;
            ST_CMP: begin
                n_state = (r_sq > {{(SQ_W - CAND_W){1'b0}}, r_n}) ? ST_UPD : ST_WAITA;
            end
            ST_WAITA: begin
                if (w_rsp.done) begin
                    n_state = w_rsp.zero ? ST_UPD : ST_WAITB;
                end
            end
            ST_WAITB: begin
                if (w_rsp.done) begin
                    n_state = w_rsp.zero ? ST_UPD : ST_MUL;
                end
            end
            ST_UPD: n_state = ST_RES;
            ST_RES: begin
                if (w_out_free) begin
                    n_state = (r_fin && (w_fill != '0)) ? ST_LIST : ST_IDLE;
                end
            end
            ST_LIST: begin
                if (w_out_free && (r_idx == '0)) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_n         = r_n;
        n_fin       = r_fin;
        n_isp       = r_isp;
        n_d         = r_d;
        n_sq        = r_sq;
        n_count     = r_count;
        n_total     = r_total;
        n_idx       = r_idx;
        n_ovalid    = r_ovalid && !m_axis_tready;
        n_odata     = r_odata;
        n_ouser     = r_ouser;
        n_olast     = r_olast;
        w_req       = '0;
        w_ins       = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_n   = s_axis_tdata[CAND_W-1:0] & VMASK;
                    n_fin = s_axis_tlast;
                end
            end
            ST_PRE: begin
                n_isp = w_small;
                if (!w_small && !w_trivial_no) begin
                    w_req.start   = 1'b1;
                    w_req.divisor = C_DIV_THREE;
                end
                n_d = C_DIV_FIRST;
            end
            ST_WAIT3: begin
                if (w_rsp.done) begin
                    n_isp = 1'b0;
                end
            end
            ST_MUL: n_sq = SQ_W'(r_d) * SQ_W'(r_d);
            ST_CMP: begin
                if (r_sq > {{(SQ_W - CAND_W){1'b0}}, r_n}) begin
                    n_isp = 1'b1;
                end else begin
                    w_req.start   = 1'b1;
                    w_req.divisor = r_d;
                end
            end
            ST_WAITA: begin
                if (w_rsp.done && !w_rsp.zero) begin
                    w_req.start   = 1'b1;
                    w_req.divisor = r_d + C_DIV_PAIR;
                end
            end
            ST_WAITB: begin
                if (w_rsp.done) begin
                    n_d = r_d + C_DIV_STEP;
                end
            end
            ST_UPD: begin
                if (r_isp) begin
                    w_ins = 1'b1;
                    if (r_count != C_COUNT_MAX) begin
                        n_count = r_count + COUNT_W'(1);
                    end
                    n_total = w_sum[TOTAL_W] ? C_TOTAL_MAX : w_sum[TOTAL_W-1:0];
                end
            end
            ST_RES: begin
                if (w_out_free) begin
                    n_ovalid = 1'b1;
                    n_ouser  = C_KIND_TEST;
                    n_olast  = !(r_fin && (w_fill != '0));
                    n_odata  = {2'b00, {CAND_W{1'b0}}, r_total, r_count, r_isp};
                    n_idx    = IDX_W'(w_fill - FILL_W'(1));
                end
            end
            ST_LIST: begin
                if (w_out_free) begin
                    n_ovalid = 1'b1;
                    n_ouser  = C_KIND_LIST;
                    n_olast  = (r_idx == '0);
                    n_odata  = {2'b00, w_rd_val, r_total, r_count, 1'b0};
                    n_idx    = r_idx - IDX_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_total  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_total  <= n_total;
            r_ovalid <= n_ovalid;
        end
        r_n     <= n_n;
        r_fin   <= n_fin;
        r_isp   <= n_isp;
        r_d     <= n_d;
        r_sq    <= n_sq;
        r_idx   <= n_idx;
        r_odata <= n_odata;
        r_ouser <= n_ouser;
        r_olast <= n_olast;
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_ouser;
    assign m_axis_tlast  = r_olast;

endmodule

// ===== rtl/pftk_chk.sv =====
// ----------------------------------------------------------------------------
// pftk_chk
// port-level checks of the prime filter and top-k tracker
// ----------------------------------------------------------------------------
module pftk_chk
    import pftk_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               s_axis_tvalid,
    input logic               s_axis_tready,
    input logic               m_axis_tvalid,
    input logic               m_axis_tready,
    input logic [ODATA_W-1:0] m_axis_tdata,
    input logic               m_axis_tuser,
    input logic               m_axis_tlast
);

    // one request at a time: not ready right after taking one
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("ready stayed high after a request");

    // nothing new appears while idle
    a_quiet_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tready && !s_axis_tvalid && !m_axis_tvalid) |=> !m_axis_tvalid)
        else $error("result emitted while idle");

    // list entries never carry a prime flag
    a_list_no_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser == C_KIND_LIST)) |-> !m_axis_tdata[0])
        else $error("list entry with prime flag");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
        (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
        else $error("stalled result changed");

endmodule

bind prime_filter_top_k_tracker pftk_chk u_pftk_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// prime test requests against a local predictor of count, sum and largest list
// ----------------------------------------------------------------------------
module testbench;
    import pftk_pkg::*;

    localparam int DEPTH     = 10;
    localparam int IDLE_PCT  = 31;
    localparam int WDOG_MAX  = 2000000;

    typedef struct packed {
        logic [CAND_W-1:0] cand;
        logic              fin;
    } t_req;

    typedef struct packed {
        logic               kind;
        logic               flag;
        logic [COUNT_W-1:0] count;
        logic [TOTAL_W-1:0] total;
        logic [CAND_W-1:0]  value;
        logic               last;
    } t_res;

    logic               i_clk;
    logic               i_rst_n;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [31:0]        s_axis_tdata;   // [30:0] candidate, [31] zero
    logic               s_axis_tlast;   // final_item
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    logic [ODATA_W-1:0] m_axis_tdata;   // [0] flag, [31:1] count, [94:32] total, [125:95] value
    logic               m_axis_tuser;   // kind
    logic               m_axis_tlast;   // end_of_run

    prime_filter_top_k_tracker u_dut (.*);

    // pending requests and expected results
    t_req pending_reqs[$];
    t_res expected_results[$];

    // predictor state
    logic [CAND_W-1:0]  top_list[DEPTH];
    int                 top_fill;
    logic [COUNT_W-1:0] prime_cnt;
    logic [TOTAL_W-1:0] prime_sum;

    int  errors;
    int  idle_stretch;   // no idling while non-zero
    int  hold_off;       // long receiver stall
    int  quiet_cycles;

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    function automatic bit check_prime(logic [CAND_W-1:0] n);
        longint unsigned v, d;
        v = n;
        if (v == 2 || v == 3) return 1'b1;
        if (v < 2 || v % 2 == 0 || v % 3 == 0) return 1'b0;
        for (d = 5; d * d <= v; d += 6)
            if (v % d == 0 || v % (d + 2) == 0) return 1'b0;
        return 1'b1;
    endfunction

    // update running stats for one request and queue its results
    task automatic predict_primes(t_req r);
        bit               isp;
        logic [CAND_W-1:0] tmp;
        int               i;
        t_res             res;
        isp = check_prime(r.cand);
        if (isp) begin
            if (prime_cnt != C_COUNT_MAX) prime_cnt++;
            if (C_TOTAL_MAX - prime_sum < TOTAL_W'(r.cand)) prime_sum = C_TOTAL_MAX;
            else prime_sum = prime_sum + TOTAL_W'(r.cand);
            i = -1;
            if (top_fill < DEPTH) begin
                top_list[top_fill] = r.cand;
                top_fill++;
                i = top_fill - 1;
            end else if (top_list[DEPTH-1] <= r.cand) begin
                top_list[DEPTH-1] = r.cand;
                i = DEPTH - 1;
            end
            // insertion sort, descending
            while (i > 0 && top_list[i] > top_list[i-1]) begin
                tmp = top_list[i];
                top_list[i] = top_list[i-1];
                top_list[i-1] = tmp;
                i--;
            end
        end
        res.kind  = C_KIND_TEST;
        res.flag  = isp;
        res.count = prime_cnt;
        res.total = prime_sum;
        res.value = '0;
        res.last  = !(r.fin && top_fill > 0);
        expected_results.push_back(res);
        if (r.fin)
            for (i = top_fill; i > 0; i--) begin
                res.kind  = C_KIND_LIST;
                res.flag  = 1'b0;
                res.value = top_list[i-1];
                res.last  = (i == 1);
                expected_results.push_back(res);
            end
    endtask

    function automatic t_req mk(logic [CAND_W-1:0] c, logic f);
        t_req r;
        r.cand = c;
        r.fin  = f;
        return r;
    endfunction

    // small primes give deep lists; large ones exercise long trial loops rarely
    function automatic logic [CAND_W-1:0] rand_cand();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 55) return CAND_W'($urandom_range(0, 5000));
        if (sel < 80) return CAND_W'($urandom_range(0, 200000));
        if (sel < 95) return CAND_W'(($urandom() & 32'h7fff_ffff) | 32'h1);
        return CAND_W'($urandom());
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tlast  <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (s_axis_tvalid) predict_primes(mk(s_axis_tdata[CAND_W-1:0], s_axis_tlast));
            if (pending_reqs.size() > 0 &&
                (idle_stretch > 0 || $urandom_range(0, 99) >= IDLE_PCT)) begin
                t_req r;
                r = pending_reqs.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {1'b0, r.cand};
                s_axis_tlast  <= r.fin;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // monitor and receiver stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_results.size() == 0) begin
                    $error("result with nothing expected");
                    errors++;
                end else begin
                    t_res e;
                    e = expected_results.pop_front();
                    if (m_axis_tuser !== e.kind) begin
                        $error("kind exp %0h got %0h", e.kind, m_axis_tuser); errors++;
                    end
                    if (m_axis_tdata[0] !== e.flag) begin
                        $error("prime_flag exp %0h got %0h", e.flag, m_axis_tdata[0]);
                        errors++;
                    end
                    if (m_axis_tdata[31:1] !== e.count) begin
                        $error("prime_count exp %0d got %0d", e.count, m_axis_tdata[31:1]);
                        errors++;
                    end
                    if (m_axis_tdata[94:32] !== e.total) begin
                        $error("prime_total exp %0d got %0d", e.total, m_axis_tdata[94:32]);
                        errors++;
                    end
                    if (m_axis_tdata[125:95] !== e.value) begin
                        $error("list_value exp %0d got %0d", e.value, m_axis_tdata[125:95]);
                        errors++;
                    end
                    if (m_axis_tlast !== e.last) begin
                        $error("end_of_run exp %0h got %0h", e.last, m_axis_tlast);
                        errors++;
                    end
                end
            end
            if (hold_off > 0) begin
                hold_off <= hold_off - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= (idle_stretch > 0) || ($urandom_range(0, 99) >= IDLE_PCT);
            end
            if (idle_stretch > 0) idle_stretch <= idle_stretch - 1;
        end
    end

    // watchdog on cycles with no handshake
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > WDOG_MAX) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        int n;
        errors = 0; top_fill = 0; prime_cnt = '0; prime_sum = '0;
        idle_stretch = 0; hold_off = 0; quiet_cycles = 0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0; s_axis_tdata = '0; s_axis_tlast = 1'b0;
        m_axis_tready = 1'b0;

        // directed: empty list final, edges, duplicates, full list, largest prime
        pending_reqs.push_back(mk(0, 1'b1));   // final with empty list
        pending_reqs.push_back(mk(1, 1'b0));
        pending_reqs.push_back(mk(2, 1'b0));
        pending_reqs.push_back(mk(3, 1'b1));
        pending_reqs.push_back(mk(4, 1'b0));
        pending_reqs.push_back(mk(9, 1'b0));
        pending_reqs.push_back(mk(25, 1'b0));  // 6k-1 divisor
        pending_reqs.push_back(mk(49, 1'b0));  // 6k+1 divisor
        pending_reqs.push_back(mk(3, 1'b0));   // duplicate
        pending_reqs.push_back(mk(5, 1'b0));
        pending_reqs.push_back(mk(7, 1'b0));
        pending_reqs.push_back(mk(11, 1'b0));
        pending_reqs.push_back(mk(13, 1'b0));
        pending_reqs.push_back(mk(17, 1'b0));
        pending_reqs.push_back(mk(19, 1'b0));
        pending_reqs.push_back(mk(23, 1'b1));  // list now full
        pending_reqs.push_back(mk(3, 1'b0));   // pushes out the smallest entry
        pending_reqs.push_back(mk(2, 1'b0));   // prime below full list
        pending_reqs.push_back(mk(3, 1'b1));   // equal to smallest entry
        pending_reqs.push_back(mk(31'h7fff_ffff, 1'b0)); // largest prime, all ones
        pending_reqs.push_back(mk(31'h7fff_fffe, 1'b1));
        pending_reqs.push_back(mk(2147483629, 1'b1));
        for (n = 0; n < 130; n++)
            pending_reqs.push_back(mk(rand_cand(), $urandom_range(0, 9) == 0));

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // long stall so the block fills and backs up its input
        @(posedge i_clk);
        hold_off <= 3000;
        repeat (60000) @(posedge i_clk);
        idle_stretch <= 20000;

        while (pending_reqs.size() > 0 || s_axis_tvalid || expected_results.size() > 0)
            @(negedge i_clk);
        repeat (100) @(posedge i_clk);
        if (errors == 0 && expected_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

// ===== filelist.f =====
rtl/pftk_pkg.sv
rtl/pftk_rem.sv
rtl/pftk_list.sv
rtl/prime_filter_top_k_tracker.sv
rtl/pftk_chk.sv
tb/sv/testbench.sv
